### rtl/round_robin_ready_ring_assert.svh
// Assertion macros for the round-robin ready ring.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef ROUND_ROBIN_READY_RING_ASSERT_SVH
`define ROUND_ROBIN_READY_RING_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define RRR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("round_robin_ready_ring: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define RRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("round_robin_ready_ring: assertion failed");
`else
`define RRR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define RRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

### rtl/rrr_pkg.sv
// Shared types for the round-robin ready ring: slot contents and cell commands.
// No dependencies; used by rrr_cell and round_robin_ready_ring.
package rrr_pkg;

  localparam int TASK_W = 6;

  // One ring position: occupied flag and the task id it holds.
  typedef struct packed {
    logic              v;
    logic [TASK_W-1:0] t;
  } slot_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_ROTATE,
    CMD_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [TASK_W-1:0] new_id;
    logic [TASK_W-1:0] head_id;
  } cell_ctl_t;

endpackage

### rtl/rrr_cell.sv
// One position of the ready-ring chain; holds a slot and trades it with its neighbors.
// Depends on rrr_pkg.
module rrr_cell import rrr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      left_v,
  input  slot_t     right,
  output slot_t     slot
);

  logic              v_r, v_nxt;
  logic [TASK_W-1:0] t_r, t_nxt;

  always_comb begin
    v_nxt = v_r;
    t_nxt = t_r;
    case (ctl.cmd)
      CMD_LOAD: begin
        // The first free position after the occupied run takes the new task.
        if (!v_r && left_v) begin
          v_nxt = 1'b1;
          t_nxt = ctl.new_id;
        end
      end
      CMD_ROTATE: begin
        // Left rotation of the occupied run; the tail picks up the old head.
        if (right.v) begin
          t_nxt = right.t;
        end else if (v_r) begin
          t_nxt = ctl.head_id;
        end
      end
      CMD_SHIFT: begin
        // Drop the head and close the gap.
        v_nxt = right.v;
        t_nxt = right.t;
      end
      default: begin
        v_nxt = v_r;
        t_nxt = t_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  assign slot.v = v_r;
  assign slot.t = t_r;

endmodule

### rtl/round_robin_ready_ring.sv
// Round-robin ready ring. Enqueue, yield and pick requests pass through the exec and done states;
// a dequeue that hits the head does too. Other dequeues walk the chain one cell a cycle: once
// around on a miss, or once around and then on to the match when the match sits after the head.
// One request is in work at a time; the next is taken once the result is in the output register.
// Reset (synchronous, active low) empties the ring and sets the idle id to 0; no clearing pass.
`include "round_robin_ready_ring_assert.svh"

module round_robin_ready_ring import rrr_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] op, [7:2] task_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [7:2] run_id, [8] ring_empty, rest zero
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata   // idle_task_id
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  // Request codes.
  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_DEQ   = 2'd1;
  localparam logic [1:0] OP_YIELD = 2'd2;
  localparam logic [1:0] OP_PICK  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_IDLE     = 2'd3;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SEEK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // The ring is held in order in a chain of cells: cell 0 is always the head and the
  // occupied cells form one run starting there. A rotation moves every task one cell
  // toward the head, with the head wrapping to the tail, which is exactly a yield.
  // A dequeue that misses the head rotates the ring once around, noting the last
  // rotation at which the head cell matched (the first match walking backward from
  // the head), then rotates up to that point and drops the head cell.

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [TASK_W-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  last_r, last_nxt;
  logic              found_r, found_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [TASK_W-1:0] idle_id_r;
  logic              out_valid_r, out_valid_nxt;
  logic [8:0]        out_data_r, out_data_nxt;

  cell_ctl_t         ctl;
  slot_t             slot_q [SLOTS];
  logic              head_hit;
  logic [1:0]        miss_status;

  assign head_hit    = slot_q[0].v && (slot_q[0].t == id_r);
  assign miss_status = (id_r == idle_id_r) ? STAT_IDLE : STAT_NOTFOUND;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ctl.cmd       = CMD_HOLD;
    ctl.new_id    = id_r;
    ctl.head_id   = slot_q[0].t;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[1:0];
          id_nxt    = in_tdata[7:2];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_DONE;
        status_nxt = STAT_OK;
        case (op_r)
          OP_ENQ: begin
            if (cnt_r == CNT_W'(SLOTS)) begin
              status_nxt = STAT_FULL;
            end else begin
              ctl.cmd = CMD_LOAD;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          OP_DEQ: begin
            if (cnt_r == '0) begin
              status_nxt = miss_status;
            end else if (head_hit) begin
              ctl.cmd = CMD_SHIFT;
              cnt_nxt = cnt_r - CNT_W'(1);
            end else begin
              ctl.cmd   = CMD_ROTATE;
              step_nxt  = CNT_W'(1);
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          OP_YIELD: begin
            // An empty ring has no occupied cell, so the rotation changes nothing.
            ctl.cmd = CMD_ROTATE;
          end
          OP_PICK: begin
            ctl.cmd = CMD_HOLD;
          end
          default: begin
            ctl.cmd = CMD_HOLD;
          end
        endcase
      end
      S_SCAN: begin
        // The head cell holds the task that sat step_r places after the head.
        if (step_r == cnt_r) begin
          if (found_r) begin
            step_nxt  = '0;
            state_nxt = S_SEEK;
          end else begin
            status_nxt = miss_status;
            state_nxt  = S_DONE;
          end
        end else begin
          if (head_hit) begin
            last_nxt  = step_r;
            found_nxt = 1'b1;
          end
          ctl.cmd  = CMD_ROTATE;
          step_nxt = step_r + CNT_W'(1);
        end
      end
      S_SEEK: begin
        if (step_r == last_r) begin
          // The matched task is at the head; its successor becomes the new head.
          ctl.cmd    = CMD_SHIFT;
          cnt_nxt    = cnt_r - CNT_W'(1);
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
        end else begin
          ctl.cmd  = CMD_ROTATE;
          step_nxt = step_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {!slot_q[0].v,
                           slot_q[0].v ? slot_q[0].t : idle_id_r,
                           status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      idle_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        idle_id_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    step_r     <= step_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Chain of cells; the ends see a permanently occupied left side and an empty right side.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic  left_v;
    slot_t right;
    if (i == 0) begin : g_first
      assign left_v = 1'b1;
    end else begin : g_mid_l
      assign left_v = slot_q[i-1].v;
    end
    if (i == SLOTS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = slot_q[i+1];
    end
    rrr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .left_v (left_v),
      .right  (right),
      .slot   (slot_q[i])
    );
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r};

  `RRR_ASSERT_NOW(a_head_matches_count, clk, rst_n, 1'b1, slot_q[0].v == (cnt_r != '0))
  `RRR_ASSERT_NOW(a_full_tail, clk, rst_n, cnt_r == CNT_W'(SLOTS), slot_q[SLOTS-1].v)
  `RRR_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_tvalid && in_tready, state_r == S_EXEC)
  `RRR_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == S_SCAN, step_r <= cnt_r)
  `RRR_ASSERT_NOW(a_seek_bound, clk, rst_n, state_r == S_SEEK, found_r && step_r <= last_r)

endmodule

### test/round_robin_ready_ring_tb.sv
// Self-checking testbench for round_robin_ready_ring: a ready-ring predictor and result scoreboard
// in a small package, then the top module that drives requests and checks results.
// Depends on rrr_pkg and the round_robin_ready_ring RTL.
`timescale 1ns / 100ps

package rrr_tb_pkg;
  import rrr_pkg::TASK_W;

  localparam int POOL = 64;
  localparam int NIL = POOL;

  typedef enum bit [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_YIELD   = 2'd2,
    OP_PICK    = 2'd3
  } ring_op_e;

  typedef enum bit [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_IDLE_IGNORED = 2'd3
  } ring_status_e;

  typedef struct packed {
    bit [TASK_W-1:0] task_id;
    ring_op_e        op;
  } ring_request_t;

  typedef struct packed {
    bit [6:0]        pad;
    bit              empty;
    bit [TASK_W-1:0] run_id;
    ring_status_e    status;
  } ring_result_t;

  class run_queue_checker;
    bit [TASK_W-1:0] slot_id [POOL];
    bit [6:0]        link_fwd [POOL];
    bit [6:0]        link_back [POOL];
    bit [6:0]        free_slot;
    bit [6:0]        head_slot;
    bit [TASK_W-1:0] idle_id;
    ring_result_t    expected_heads [$];
    int unsigned     requests;
    int unsigned     results;
    int unsigned     errors;
    int unsigned     status_seen [4];
    int unsigned     peak_depth;

    function new();
      for (int i = 0; i < POOL; i++) begin
        slot_id[i] = '0;
        link_fwd[i] = 7'(i + 1);
        link_back[i] = 7'(NIL);
      end
      free_slot = '0;
      head_slot = 7'(NIL);
      idle_id = '0;
      requests = 0;
      results = 0;
      errors = 0;
      peak_depth = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit in_pool(bit [6:0] s);
      return s < POOL;
    endfunction

    function ring_status_e insert_task(bit [TASK_W-1:0] id);
      bit [6:0] n;
      bit [6:0] p;
      n = free_slot;
      if (!in_pool(n)) return ST_FULL;
      free_slot = link_fwd[n];
      slot_id[n] = id;
      if (!in_pool(head_slot)) begin
        head_slot = n;
        link_fwd[n] = n;
        link_back[n] = n;
      end else begin
        // The new task lands just before the head, i.e. at the tail of the round.
        p = link_back[head_slot];
        if (in_pool(p)) link_fwd[p] = n;
        link_back[n] = p;
        link_back[head_slot] = n;
        link_fwd[n] = head_slot;
      end
      return ST_OK;
    endfunction

    function ring_status_e remove_task(bit [TASK_W-1:0] id);
      bit [6:0] c;
      bit [6:0] p;
      bit [6:0] n;
      bit       found;
      found = 0;
      c = head_slot;
      if (in_pool(head_slot)) begin
        if (slot_id[head_slot] == id) begin
          found = 1;
        end else begin
          // Walk backward from the head; the walk is bounded by the pool size.
          c = link_back[head_slot];
          for (int k = 0; k < POOL; k++) begin
            if (!in_pool(c) || c == head_slot) break;
            if (slot_id[c] == id) begin
              found = 1;
              break;
            end
            c = link_back[c];
          end
        end
      end
      if (!found) return (id == idle_id) ? ST_IDLE_IGNORED : ST_NOT_FOUND;
      if (link_fwd[c] == c) begin
        head_slot = 7'(NIL);
      end else begin
        p = link_back[c];
        n = link_fwd[c];
        if (in_pool(p)) link_fwd[p] = n;
        if (in_pool(n)) link_back[n] = p;
        head_slot = in_pool(n) ? n : 7'(NIL);
      end
      link_fwd[c] = free_slot;
      free_slot = c;
      return ST_OK;
    endfunction

    function int unsigned ring_depth();
      bit [6:0]    c;
      int unsigned d;
      d = 0;
      c = head_slot;
      while (in_pool(c) && d < POOL) begin
        d++;
        c = link_fwd[c];
        if (c == head_slot) break;
      end
      return d;
    endfunction

    // A task id that sits in the ring right now, or any id when the ring is empty.
    function bit [TASK_W-1:0] live_task();
      bit [6:0]        c;
      bit [TASK_W-1:0] pick;
      int unsigned     seen;
      seen = 0;
      c = head_slot;
      pick = TASK_W'($urandom_range(63));
      while (in_pool(c) && seen < POOL) begin
        seen++;
        if ($urandom_range(seen - 1) == 0) pick = slot_id[c];
        c = link_fwd[c];
        if (c == head_slot) break;
      end
      return pick;
    endfunction

    function void note_request(bit [7:0] data);
      ring_request_t rq;
      ring_result_t  want;
      ring_status_e  st;
      int unsigned   d;
      rq = data;
      st = ST_OK;
      case (rq.op)
        OP_ENQUEUE: st = insert_task(rq.task_id);
        OP_DEQUEUE: st = remove_task(rq.task_id);
        OP_YIELD: begin
          if (in_pool(head_slot))
            head_slot = in_pool(link_fwd[head_slot]) ? link_fwd[head_slot] : 7'(NIL);
        end
        default: ;
      endcase
      want.pad = '0;
      want.empty = !in_pool(head_slot);
      want.run_id = want.empty ? idle_id : slot_id[head_slot];
      want.status = st;
      expected_heads.push_back(want);
      requests++;
      d = ring_depth();
      if (d > peak_depth) peak_depth = d;
    endfunction

    function void check_result(bit [15:0] data);
      ring_result_t got;
      ring_result_t want;
      got = data;
      if (expected_heads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h with no request outstanding", data);
        return;
      end
      want = expected_heads.pop_front();
      results++;
      status_seen[want.status]++;
      if (got.status != want.status || got.run_id != want.run_id ||
          got.empty != want.empty || got.pad != want.pad) begin
        errors++;
        if (errors <= 10)
          $display("Result %0d mismatch: expected status %0d run_id %0d empty %0b pad %h, %s",
                   results, want.status, want.run_id, want.empty, want.pad,
                   $sformatf("got status %0d run_id %0d empty %0b pad %h",
                             got.status, got.run_id, got.empty, got.pad));
      end
    endfunction

    function int unsigned pending();
      return expected_heads.size();
    endfunction
  endclass
endpackage

module round_robin_ready_ring_tb;
  import rrr_tb_pkg::*;

  // The quiet limit also covers the long output stall.
  localparam int LONG_STALL  = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [1:0] op, [7:2] task_id
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] status, [7:2] run_id, [8] ring_empty, rest zero
  logic        cfg_we;
  logic [5:0]  cfg_wdata;  // idle_task_id

  run_queue_checker ring_sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          stall_request;
  int unsigned quiet_cycles;

  round_robin_ready_ring #(
    .SLOTS(POOL)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Handshake monitor. Inputs are driven with nonblocking assignments at the edge, so the
  // values seen here are the ones the block samples at the same edge. The result is
  // checked before the new request is noted; a result never belongs to a request that
  // is accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) ring_sb.check_result(out_tdata);
      if (in_tvalid && in_tready) ring_sb.note_request(in_tdata);
    end
  end

  // Watchdog: counts consecutive cycles in which neither side completes a handshake.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("No handshake for %0d cycles, %0d results still owed",
                 QUIET_LIMIT, ring_sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result receiver. It drops ready at random by recv_idle_pct, and on request it holds
  // off for a long stretch so that the one request in work and the full output register
  // back up into in_tready while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request, with random idle cycles in front of it, and returns at the edge
  // at which it is accepted. Valid stays high so back-to-back requests need no gap.
  task automatic send_request(ring_op_e op, bit [5:0] id);
    ring_request_t rq;
    rq.op = op;
    rq.task_id = id;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every request has produced its result. Every request
  // gives exactly one result, so an empty scoreboard means the block is idle.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ring_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The idle id may only change while no request is in work.
  task automatic write_idle_id(bit [5:0] id);
    drain_requests();
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_sb.idle_id = id;
  endtask

  // Random requests with a given share of enqueues and dequeues; the rest are yields and
  // picks. Most dequeues name a task that is in the ring, so that hits land at every depth
  // of the backward walk; some name the idle id and some any id.
  task automatic run_mix(int unsigned count, int unsigned enq_pct, int unsigned deq_pct);
    int unsigned r;
    int unsigned s;
    bit [5:0]    id;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < enq_pct) begin
        // A third of the ids come from a narrow range so duplicates are common.
        id = ($urandom_range(2) == 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
        send_request(OP_ENQUEUE, id);
      end else if (r < enq_pct + deq_pct) begin
        s = $urandom_range(7);
        if (s < 6) id = ring_sb.live_task();
        else if (s == 6) id = ring_sb.idle_id;
        else id = 6'($urandom_range(63));
        send_request(OP_DEQUEUE, id);
      end else begin
        send_request($urandom_range(1) ? OP_YIELD : OP_PICK, 6'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    int unsigned idle_plan [3][2];
    idle_plan = '{'{22, 53}, '{53, 22}, '{0, 0}};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. The empty ring comes first: pick and yield report the idle id,
    // and a dequeue is ignored for the idle id and not found for any other.
    write_idle_id(6'd9);
    send_request(OP_PICK, 6'd0);
    send_request(OP_YIELD, 6'd63);
    send_request(OP_DEQUEUE, 6'd9);
    send_request(OP_DEQUEUE, 6'd0);
    // Extreme ids, a duplicate, and the idle id living in the ring as a real task.
    send_request(OP_ENQUEUE, 6'd0);
    send_request(OP_ENQUEUE, 6'd63);
    send_request(OP_ENQUEUE, 6'd63);
    send_request(OP_ENQUEUE, 6'd9);
    send_request(OP_PICK, 6'd63);
    send_request(OP_YIELD, 6'd0);
    send_request(OP_YIELD, 6'd0);
    // A hit deep behind the head, then the same idle id missing, then a plain miss.
    send_request(OP_DEQUEUE, 6'd9);
    send_request(OP_DEQUEUE, 6'd9);
    send_request(OP_DEQUEUE, 6'd42);
    // Hits on the head itself until the last task leaves and the ring is empty again.
    send_request(OP_DEQUEUE, 6'd0);
    send_request(OP_DEQUEUE, 6'd63);
    send_request(OP_YIELD, 6'd21);
    send_request(OP_DEQUEUE, 6'd63);
    send_request(OP_PICK, 6'd42);
    send_request(OP_YIELD, 6'd0);

    // Three idling regimes. Each fills the pool until enqueues are rejected, runs a
    // balanced mix, then drains toward empty, with a new idle id before every phase.
    for (int g = 0; g < 3; g++) begin
      send_idle_pct = idle_plan[g][0];
      recv_idle_pct = idle_plan[g][1];
      write_idle_id(g == 0 ? 6'd63 : 6'($urandom_range(63)));
      run_mix(130, 80, 10);
      write_idle_id(6'($urandom_range(63)));
      if (g == 2) stall_request = 1'b1;
      run_mix(380, 40, 40);
      write_idle_id(g == 1 ? 6'd0 : 6'($urandom_range(63)));
      run_mix(140, 10, 75);
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d requests and %0d results under three idling regimes and a long %s",
             ring_sb.requests, ring_sb.results, "output stall.");
    $display("Status mix: ok %0d, full %0d, not found %0d, idle ignored %0d; peak depth %0d.",
             ring_sb.status_seen[ST_OK], ring_sb.status_seen[ST_FULL],
             ring_sb.status_seen[ST_NOT_FOUND], ring_sb.status_seen[ST_IDLE_IGNORED],
             ring_sb.peak_depth);
    if (ring_sb.errors == 0 && ring_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", ring_sb.errors, ring_sb.pending());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
